/* src/cske_pkg.sv */
// ----------------------------------------------------------------------------
// cske_pkg
// Types, codes and helpers shared by the clock-set keypad editor modules.
// ----------------------------------------------------------------------------
package cske_pkg;

  localparam int unsigned CntW = 16;
  localparam logic [CntW-1:0] COUNT_MAX = '1;
  localparam logic [CntW-1:0] THRESHOLD_RESET = 16'd500;

  localparam logic [3:0] BCD_UNITS_MAX   = 4'd9;
  localparam logic [3:0] HOUR_WRAP_TENS  = 4'd2;
  localparam logic [3:0] HOUR_WRAP_UNITS = 4'd4;
  localparam logic [3:0] MINSEC_WRAP_TENS = 4'd6;

  typedef enum logic {
    OP_POLL = 1'b0,
    OP_LOAD = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    KEY_NONE   = 2'd0,
    KEY_ADJUST = 2'd1,
    KEY_SELECT = 2'd2,
    KEY_OTHER  = 2'd3
  } key_t;

  typedef enum logic [1:0] {
    FIELD_HOURS   = 2'd0,
    FIELD_MINUTES = 2'd1,
    FIELD_SECONDS = 2'd2,
    FIELD_UNUSED  = 2'd3
  } field_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [1:0] key_state;
    logic [7:0] load_hours;
    logic [7:0] load_minutes;
    logic [7:0] load_seconds;
  } item_t;

  typedef struct packed {
    logic [7:0] hours_bcd;
    logic [7:0] minutes_bcd;
    logic [7:0] seconds_bcd;
    logic [1:0] selected_field;
    logic       commit;
    logic       exit_to_menu;
  } result_t;

  typedef struct packed {
    logic [CntW-1:0] select_cnt;
    logic [CntW-1:0] adjust_cnt;
    logic [1:0]      field_sel;
    logic [7:0]      hours;
    logic [7:0]      minutes;
    logic [7:0]      seconds;
  } edit_state_t;

  // units step with carry into a 4-bit tens digit, then the field wrap rule
  function automatic logic [7:0] bcd_bump(input logic [7:0] v, input logic is_hours);
    logic [3:0] units;
    logic [3:0] tens;
    units = v[3:0];
    tens  = v[7:4];
    if (units >= BCD_UNITS_MAX) begin
      units = 4'd0;
      tens  = tens + 4'd1;
    end else begin
      units = units + 4'd1;
    end
    if (is_hours) begin
      if (tens == HOUR_WRAP_TENS && units == HOUR_WRAP_UNITS) begin
        tens  = 4'd0;
        units = 4'd0;
      end
    end else if (tens == MINSEC_WRAP_TENS) begin
      tens  = 4'd0;
      units = 4'd0;
    end
    return {tens, units};
  endfunction

endpackage

/* src/cske_step.sv */
// ----------------------------------------------------------------------------
// cske_step
// Next-state and result logic for one poll or time load.
// ----------------------------------------------------------------------------
module cske_step import cske_pkg::*; (
  input  item_t           item,
  input  edit_state_t     cur,
  input  logic [CntW-1:0] threshold,
  output edit_state_t     nxt,
  output result_t         res
);

  logic       commit;
  logic       leave;
  logic [1:0] sel_after;

  always_comb begin
    nxt       = cur;
    commit    = 1'b0;
    leave     = 1'b0;
    sel_after = cur.field_sel;

    if (item.opcode == OP_LOAD) begin
      nxt.hours   = item.load_hours;
      nxt.minutes = item.load_minutes;
      nxt.seconds = item.load_seconds;
    end else begin
      if (item.key_state == KEY_SELECT && cur.select_cnt != COUNT_MAX) begin
        nxt.select_cnt = cur.select_cnt + 1'b1;
      end
      if (item.key_state == KEY_ADJUST && cur.adjust_cnt != COUNT_MAX) begin
        nxt.adjust_cnt = cur.adjust_cnt + 1'b1;
      end

      if (item.key_state == KEY_NONE && cur.select_cnt != '0) begin
        if (cur.select_cnt >= threshold) begin
          leave = 1'b1;
        end else begin
          case (cur.field_sel)
            FIELD_HOURS:   sel_after = FIELD_MINUTES;
            FIELD_MINUTES: sel_after = FIELD_SECONDS;
            FIELD_SECONDS: sel_after = FIELD_HOURS;
            default:       sel_after = FIELD_HOURS;
          endcase
        end
        nxt.select_cnt = '0;
      end
      nxt.field_sel = sel_after;

      // adjust sees the selector after any select action
      if (item.key_state == KEY_NONE && cur.adjust_cnt != '0) begin
        if (cur.adjust_cnt >= threshold) begin
          commit = 1'b1;
        end else begin
          case (sel_after)
            FIELD_HOURS:   nxt.hours   = bcd_bump(cur.hours, 1'b1);
            FIELD_MINUTES: nxt.minutes = bcd_bump(cur.minutes, 1'b0);
            FIELD_SECONDS: nxt.seconds = bcd_bump(cur.seconds, 1'b0);
            default:       ;
          endcase
        end
        nxt.adjust_cnt = '0;
      end
    end
  end

  always_comb begin
    res.hours_bcd      = nxt.hours;
    res.minutes_bcd    = nxt.minutes;
    res.seconds_bcd    = nxt.seconds;
    res.selected_field = nxt.field_sel;
    res.commit         = commit;
    res.exit_to_menu   = leave;
  end

endmodule

/* src/clock_set_keypad_editor_top.sv */
// ----------------------------------------------------------------------------
// clock_set_keypad_editor_top
// Keypad-driven time-setting editor with short/long press handling.
// ----------------------------------------------------------------------------
// Each input item is a keypad poll or a load of the current BCD time and
// gives exactly one result item: the edited time, the selected field and
// the commit / exit-to-menu flags. An item passes an input register and one
// step of logic into the output register, so the block takes one item per
// clock while out_tready stays high; the editor state is updated as the
// item moves into the output register.
// long_press_threshold is written through cfg_wr_en / cfg_wr_data and
// resets to 500.
// ----------------------------------------------------------------------------
module clock_set_keypad_editor_top import cske_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,   // long_press_threshold
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,      // key_state[1:0], load_hours[9:2],
                                     // load_minutes[17:10], load_seconds[25:18]
  input  logic [0:0]  in_tuser,      // opcode[0]
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata      // hours_bcd[7:0], minutes_bcd[15:8],
                                     // seconds_bcd[23:16], selected_field[25:24],
                                     // commit[26], exit_to_menu[27]
);

  logic [CntW-1:0] thr_r;
  edit_state_t     state_r;
  edit_state_t     state_nxt;
  logic            s1_valid_r;
  item_t           s1_item_r;
  logic            out_valid_r;
  result_t         out_res_r;
  result_t         res_nxt;

  logic out_free;
  logic s1_fire;
  logic in_fire;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  cske_step u_step (
    .item      (s1_item_r),
    .cur       (state_r),
    .threshold (thr_r),
    .nxt       (state_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.opcode       <= opcode_t'(in_tuser[0]);
      s1_item_r.key_state    <= in_tdata[1:0];
      s1_item_r.load_hours   <= in_tdata[9:2];
      s1_item_r.load_minutes <= in_tdata[17:10];
      s1_item_r.load_seconds <= in_tdata[25:18];
    end
    if (s1_fire) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0,
                       out_res_r.exit_to_menu,
                       out_res_r.commit,
                       out_res_r.selected_field,
                       out_res_r.seconds_bcd,
                       out_res_r.minutes_bcd,
                       out_res_r.hours_bcd};

endmodule
